[rtl/core/trs_pkg.sv]
// shared types and constants for the telemetry ring summary block
package trs_pkg;

	localparam int DATA_W    = 16;
	localparam int PAYLOAD_W = 32;
	localparam int CNT_W     = 5;
	localparam int SUM_W     = 20;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_SAT   = 2'd1,
		KIND_EXP   = 2'd2,
		KIND_RSVD  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_STORE_SAT = 2'd0,
		ACT_STORE_EXP = 2'd1,
		ACT_SUMMARY   = 2'd2,
		ACT_NONE      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	typedef struct packed {
		kind_t                 kind;
		logic [PAYLOAD_W-1:0]  payload;
	} slot_t;

	typedef struct packed {
		logic clear;
		logic en;
	} acc_ctl_t;

	// start values of the running extremes
	localparam logic signed [DATA_W-1:0] TEMP_MAX_START = -16'sd800;
	localparam logic signed [DATA_W-1:0] TEMP_MIN_START = 16'sd3392;
	localparam logic [DATA_W-1:0]        VOLT_MAX_START = 16'd0;
	localparam logic [DATA_W-1:0]        VOLT_MIN_START = 16'd25600;

endpackage

[rtl/core/trs_accum.sv]
// running counts, sums and extremes over the slots read from the ring
module trs_accum (
	input  logic                                 clk,
	input  trs_pkg::acc_ctl_t                    ctl,
	input  trs_pkg::kind_t                       kind,
	input  logic [trs_pkg::PAYLOAD_W-1:0]        payload,
	output logic [trs_pkg::CNT_W-1:0]            satellite_records,
	output logic [trs_pkg::CNT_W-1:0]            experiment_records,
	output logic [trs_pkg::SUM_W-1:0]            radiation_total,
	output logic [trs_pkg::SUM_W-1:0]            latchup_total,
	output logic signed [trs_pkg::DATA_W-1:0]    highest_temperature,
	output logic signed [trs_pkg::DATA_W-1:0]    lowest_temperature,
	output logic [trs_pkg::DATA_W-1:0]           highest_voltage,
	output logic [trs_pkg::DATA_W-1:0]           lowest_voltage
);

	logic [trs_pkg::CNT_W-1:0]         nsat_q, nexp_q;
	logic [trs_pkg::SUM_W-1:0]         rad_q, lat_q;
	logic signed [trs_pkg::DATA_W-1:0] tmax_q, tmin_q;
	logic [trs_pkg::DATA_W-1:0]        vmax_q, vmin_q;

	logic signed [trs_pkg::DATA_W-1:0] temp;
	logic [trs_pkg::DATA_W-1:0]        volt;
	logic [trs_pkg::DATA_W-1:0]        lo_cnt, hi_cnt;
	logic                              is_sat, is_exp;

	assign temp   = signed'(payload[trs_pkg::DATA_W-1:0]);
	assign volt   = payload[trs_pkg::PAYLOAD_W-1:trs_pkg::DATA_W];
	assign lo_cnt = payload[trs_pkg::DATA_W-1:0];
	assign hi_cnt = payload[trs_pkg::PAYLOAD_W-1:trs_pkg::DATA_W];
	assign is_sat = ctl.en && (kind == trs_pkg::KIND_SAT);
	assign is_exp = ctl.en && (kind == trs_pkg::KIND_EXP);

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			nsat_q <= '0;
			nexp_q <= '0;
			rad_q  <= '0;
			lat_q  <= '0;
			tmax_q <= trs_pkg::TEMP_MAX_START;
			tmin_q <= trs_pkg::TEMP_MIN_START;
			vmax_q <= trs_pkg::VOLT_MAX_START;
			vmin_q <= trs_pkg::VOLT_MIN_START;
		end else begin
			if (is_sat) begin
				nsat_q <= nsat_q + trs_pkg::CNT_W'(1);
				if (tmax_q < temp) tmax_q <= temp;
				if (tmin_q > temp) tmin_q <= temp;
				if (vmax_q < volt) vmax_q <= volt;
				if (vmin_q > volt) vmin_q <= volt;
			end
			if (is_exp) begin
				nexp_q <= nexp_q + trs_pkg::CNT_W'(1);
				rad_q  <= rad_q + trs_pkg::SUM_W'(lo_cnt);
				lat_q  <= lat_q + trs_pkg::SUM_W'(hi_cnt);
			end
		end
	end

	assign satellite_records   = nsat_q;
	assign experiment_records  = nexp_q;
	assign radiation_total     = rad_q;
	assign latchup_total       = lat_q;
	assign highest_temperature = tmax_q;
	assign lowest_temperature  = tmin_q;
	assign highest_voltage     = vmax_q;
	assign lowest_voltage      = vmin_q;

endmodule

[rtl/core/telemetry_ring_summary.sv]
// top level: ring of tagged telemetry records with a summary walk
//
// An item is taken at a rising edge with start high and busy low. action
// selects a store of a satellite record (temperature, voltage), a store of
// an experiment record (radiation and latch-up counts), or a summary; the
// fourth code is taken and ignored.
// A store writes the slot at the write pointer and advances the pointer with
// wrap; busy stays low, so stores can come every cycle outside a summary walk.
// A summary walks the ring through the single read port of the slot
// memory, one slot per cycle; the registered read and the last
// accumulate then finish in a drain state with busy still high. The result
// is shown with done high for one cycle, in the state after the drain; a
// new item may be taken in that same cycle.
// The receiver cannot stall: done lasts exactly one cycle.
// Reset clears the write pointer and the per-slot valid bits, so every slot
// reads as empty; no clearing pass is needed.
module telemetry_ring_summary #(
	parameter int RING_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        action,
	input  logic signed [trs_pkg::DATA_W-1:0] temperature,
	input  logic [trs_pkg::DATA_W-1:0]        voltage,
	input  logic [trs_pkg::DATA_W-1:0]        radiation_count,
	input  logic [trs_pkg::DATA_W-1:0]        latchup_count,
	output logic                              done,
	output logic [trs_pkg::CNT_W-1:0]         satellite_records,
	output logic [trs_pkg::CNT_W-1:0]         experiment_records,
	output logic [trs_pkg::SUM_W-1:0]         radiation_total,
	output logic [trs_pkg::SUM_W-1:0]         latchup_total,
	output logic signed [trs_pkg::DATA_W-1:0] highest_temperature,
	output logic signed [trs_pkg::DATA_W-1:0] lowest_temperature,
	output logic [trs_pkg::DATA_W-1:0]        highest_voltage,
	output logic [trs_pkg::DATA_W-1:0]        lowest_voltage
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	trs_pkg::slot_t    ring_mem_q [RING_DEPTH];
	logic [RING_DEPTH-1:0] slot_vld_q;
	logic [IDX_W-1:0]  wp_q;
	logic [IDX_W-1:0]  rd_idx_q;

	trs_pkg::state_t   state_q, state_d;
	trs_pkg::action_t  act;
	trs_pkg::acc_ctl_t acc_ctl;
	trs_pkg::slot_t    wr_slot;
	trs_pkg::slot_t    rd_slot_s1;
	trs_pkg::kind_t    rd_kind;
	logic              rd_vld_s1;
	logic              rd_en_s1;
	logic              rd_en;
	logic              accept;
	logic              do_store;
	logic              go_walk;

	assign act      = trs_pkg::action_t'(action);
	assign accept   = start && !busy;
	assign do_store = accept
		&& (act == trs_pkg::ACT_STORE_SAT || act == trs_pkg::ACT_STORE_EXP);
	assign go_walk  = accept && (act == trs_pkg::ACT_SUMMARY);

	always_comb begin
		wr_slot = '0;
		if (act == trs_pkg::ACT_STORE_SAT) begin
			wr_slot.kind    = trs_pkg::KIND_SAT;
			wr_slot.payload = {voltage, temperature};
		end else begin
			wr_slot.kind    = trs_pkg::KIND_EXP;
			wr_slot.payload = {latchup_count, radiation_count};
		end
	end

	// slot memory: one write port for stores, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (do_store) ring_mem_q[wp_q] <= wr_slot;
		if (rd_en) rd_slot_s1 <= ring_mem_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			wp_q       <= '0;
			rd_idx_q   <= '0;
			rd_en_s1   <= 1'b0;
			rd_vld_s1  <= 1'b0;
			state_q    <= trs_pkg::ST_IDLE;
		end else begin
			state_q  <= state_d;
			rd_en_s1 <= rd_en;
			if (rd_en) rd_vld_s1 <= slot_vld_q[rd_idx_q];
			if (do_store) begin
				slot_vld_q[wp_q] <= 1'b1;
				wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + IDX_W'(1);
			end
			if (go_walk) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			trs_pkg::ST_IDLE:   if (go_walk) state_d = trs_pkg::ST_WALK;
			trs_pkg::ST_WALK:   if (rd_idx_q == LAST_IDX) state_d = trs_pkg::ST_DRAIN;
			trs_pkg::ST_DRAIN:  state_d = trs_pkg::ST_REPORT;
			trs_pkg::ST_REPORT: state_d = go_walk ? trs_pkg::ST_WALK : trs_pkg::ST_IDLE;
			default:            state_d = trs_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy = 1'b0;
		done = 1'b0;
		rd_en = 1'b0;
		unique case (state_q)
			trs_pkg::ST_IDLE:   ;
			trs_pkg::ST_WALK: begin
				busy  = 1'b1;
				rd_en = 1'b1;
			end
			trs_pkg::ST_DRAIN:  busy = 1'b1;
			trs_pkg::ST_REPORT: done = 1'b1;
			default:            ;
		endcase
	end

	// a slot never written reads as empty
	assign rd_kind       = rd_vld_s1 ? rd_slot_s1.kind : trs_pkg::KIND_EMPTY;
	assign acc_ctl.clear = go_walk;
	assign acc_ctl.en    = rd_en_s1;

	trs_accum u_accum (
		.clk                 (clk),
		.ctl                 (acc_ctl),
		.kind                (rd_kind),
		.payload             (rd_slot_s1.payload),
		.satellite_records   (satellite_records),
		.experiment_records  (experiment_records),
		.radiation_total     (radiation_total),
		.latchup_total       (latchup_total),
		.highest_temperature (highest_temperature),
		.lowest_temperature  (lowest_temperature),
		.highest_voltage     (highest_voltage),
		.lowest_voltage      (lowest_voltage)
	);

endmodule

[sim/trs_summary_checker.sv]
// checker for the telemetry ring summary: tracks the ring, predicts each summary, compares results
module trs_summary_checker
	import trs_pkg::*;
#(
	parameter int RING_DEPTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [1:0]                action,
	input  logic signed [DATA_W-1:0]  temperature,
	input  logic [DATA_W-1:0]         voltage,
	input  logic [DATA_W-1:0]         radiation_count,
	input  logic [DATA_W-1:0]         latchup_count,
	input  logic                      done,
	input  logic [CNT_W-1:0]          satellite_records,
	input  logic [CNT_W-1:0]          experiment_records,
	input  logic [SUM_W-1:0]          radiation_total,
	input  logic [SUM_W-1:0]          latchup_total,
	input  logic signed [DATA_W-1:0]  highest_temperature,
	input  logic signed [DATA_W-1:0]  lowest_temperature,
	input  logic [DATA_W-1:0]         highest_voltage,
	input  logic [DATA_W-1:0]         lowest_voltage,
	output int                        failures,
	output int                        pending
);

	typedef struct {
		logic [CNT_W-1:0]         sats;
		logic [CNT_W-1:0]         exps;
		logic [SUM_W-1:0]         rad;
		logic [SUM_W-1:0]         lat;
		logic signed [DATA_W-1:0] t_hi;
		logic signed [DATA_W-1:0] t_lo;
		logic [DATA_W-1:0]        v_hi;
		logic [DATA_W-1:0]        v_lo;
	} ring_summary_t;

	slot_t         ring_copy [RING_DEPTH];
	int            wr_slot;
	ring_summary_t summary_q [$];
	ring_summary_t want;
	int            fault_count;

	// walk the ring the way the block does: extremes move only on a strict compare
	function automatic ring_summary_t summarize_ring();
		ring_summary_t            s;
		logic signed [DATA_W-1:0] t;
		logic [DATA_W-1:0]        v;
		s.sats = '0;
		s.exps = '0;
		s.rad  = '0;
		s.lat  = '0;
		s.t_hi = TEMP_MAX_START;
		s.t_lo = TEMP_MIN_START;
		s.v_hi = VOLT_MAX_START;
		s.v_lo = VOLT_MIN_START;
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (ring_copy[i].kind == KIND_SAT) begin
				t = ring_copy[i].payload[DATA_W-1:0];
				v = ring_copy[i].payload[PAYLOAD_W-1:DATA_W];
				s.sats = s.sats + 1'b1;
				if (t > s.t_hi) s.t_hi = t;
				if (t < s.t_lo) s.t_lo = t;
				if (v > s.v_hi) s.v_hi = v;
				if (v < s.v_lo) s.v_lo = v;
			end else if (ring_copy[i].kind == KIND_EXP) begin
				s.exps = s.exps + 1'b1;
				s.rad  = s.rad + ring_copy[i].payload[DATA_W-1:0];
				s.lat  = s.lat + ring_copy[i].payload[PAYLOAD_W-1:DATA_W];
			end
		end
		return s;
	endfunction

	function automatic void store_record(input kind_t k, input logic [PAYLOAD_W-1:0] p);
		ring_copy[wr_slot].kind    = k;
		ring_copy[wr_slot].payload = p;
		wr_slot = (wr_slot == RING_DEPTH - 1) ? 0 : wr_slot + 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_copy[i].kind    = KIND_EMPTY;
				ring_copy[i].payload = '0;
			end
			wr_slot = 0;
			summary_q.delete();
			fault_count = 0;
		end else begin
			// a result leaving and a new item arriving can share one edge
			if (done) begin
				if (summary_q.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: summary result with none outstanding", $time);
				end else begin
					want = summary_q.pop_front();
					if (satellite_records !== want.sats || experiment_records !== want.exps ||
							radiation_total !== want.rad || latchup_total !== want.lat ||
							highest_temperature !== want.t_hi ||
							lowest_temperature !== want.t_lo ||
							highest_voltage !== want.v_hi || lowest_voltage !== want.v_lo) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("%0t: summary mismatch", $time);
							$display("  expected sat=%0d exp=%0d rad=%0d lat=%0d",
								want.sats, want.exps, want.rad, want.lat);
							$display("           temp hi/lo=%0d/%0d volt hi/lo=%0d/%0d",
								want.t_hi, want.t_lo, want.v_hi, want.v_lo);
							$display("  actual   sat=%0d exp=%0d rad=%0d lat=%0d",
								satellite_records, experiment_records,
								radiation_total, latchup_total);
							$display("           temp hi/lo=%0d/%0d volt hi/lo=%0d/%0d",
								highest_temperature, lowest_temperature,
								highest_voltage, lowest_voltage);
						end
					end
				end
			end
			if (start && !busy) begin
				case (action_t'(action))
					ACT_STORE_SAT: store_record(KIND_SAT, {voltage, temperature});
					ACT_STORE_EXP: store_record(KIND_EXP, {latchup_count, radiation_count});
					ACT_SUMMARY:   summary_q.push_back(summarize_ring());
					default: ;
				endcase
			end
		end
		failures <= fault_count;
		pending  <= summary_q.size();
	end

endmodule

[sim/tb.sv]
// testbench top for the telemetry ring summary: stimulus, clock, reset and verdict
module tb;
	import trs_pkg::*;

	localparam int RING_DEPTH  = 8;
	localparam int ITEMS       = 800;
	localparam int CYCLE_LIMIT = 200000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               action;
	logic signed [DATA_W-1:0] temperature;
	logic [DATA_W-1:0]        voltage;
	logic [DATA_W-1:0]        radiation_count;
	logic [DATA_W-1:0]        latchup_count;
	logic                     done;
	logic [CNT_W-1:0]         satellite_records;
	logic [CNT_W-1:0]         experiment_records;
	logic [SUM_W-1:0]         radiation_total;
	logic [SUM_W-1:0]         latchup_total;
	logic signed [DATA_W-1:0] highest_temperature;
	logic signed [DATA_W-1:0] lowest_temperature;
	logic [DATA_W-1:0]        highest_voltage;
	logic [DATA_W-1:0]        lowest_voltage;
	int                       failures;
	int                       pending;
	int                       cycles;

	telemetry_ring_summary #(.RING_DEPTH(RING_DEPTH)) u_dut (.*);

	trs_summary_checker #(.RING_DEPTH(RING_DEPTH)) u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// random word, biased toward two marks and toward the sign and range extremes
	function automatic logic [DATA_W-1:0] pick_word(input logic [DATA_W-1:0] mark_a,
			input logic [DATA_W-1:0] mark_b);
		case ($urandom_range(0, 5))
			0: return DATA_W'(mark_a + $urandom_range(0, 2) - 1);
			1: return DATA_W'(mark_b + $urandom_range(0, 2) - 1);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'hffff;
					2: return 16'h7fff;
					default: return 16'h8000;
				endcase
			end
			default: return DATA_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_item(input action_t a, input logic [DATA_W-1:0] t,
			input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] rad,
			input logic [DATA_W-1:0] lat);
		start           <= 1'b1;
		action          <= a;
		temperature     <= t;
		voltage         <= v;
		radiation_count <= rad;
		latchup_count   <= lat;
		do @(posedge clk); while (busy);
	endtask

	// idle gap; the data lines carry noise while start is low
	task automatic hold_off(input int n);
		start           <= 1'b0;
		action          <= 2'($urandom_range(0, 3));
		temperature     <= DATA_W'($urandom_range(0, 65535));
		voltage         <= DATA_W'($urandom_range(0, 65535));
		radiation_count <= DATA_W'($urandom_range(0, 65535));
		latchup_count   <= DATA_W'($urandom_range(0, 65535));
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int      sat_pct;
		int      idle_pct;
		int      r;
		action_t a;

		arst_n          = 1'b0;
		start           = 1'b0;
		action          = ACT_NONE;
		temperature     = '0;
		voltage         = '0;
		radiation_count = '0;
		latchup_count   = '0;
		sat_pct         = 40;
		idle_pct        = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring gives the start values, unused code does nothing
		send_item(ACT_SUMMARY, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
		send_item(ACT_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		// full ring of maxed experiment counts, pointer wraps
		for (int i = 0; i < RING_DEPTH; i++)
			send_item(ACT_STORE_EXP, 16'h8000, 16'hffff, 16'hffff, 16'hffff);
		send_item(ACT_SUMMARY, '0, '0, '0, '0);
		// hot records at zero volts: lowest temperature and highest voltage stay at start
		send_item(ACT_STORE_SAT, 16'sd32767, 16'd0, 16'hffff, 16'h0000);
		send_item(ACT_STORE_SAT, 16'sd3393, 16'd0, 16'h0000, 16'hffff);
		send_item(ACT_SUMMARY, '0, '0, '0, '0);
		// cold records at high volts over the whole ring: the other two start values hold
		send_item(ACT_STORE_SAT, 16'h8000, 16'hffff, '0, '0);
		send_item(ACT_STORE_SAT, -16'sd801, 16'd25601, '0, '0);
		for (int i = 2; i < RING_DEPTH; i++)
			send_item(ACT_STORE_SAT, DATA_W'(-801 - $urandom_range(0, 31967)),
				DATA_W'(25601 + $urandom_range(0, 39934)),
				DATA_W'($urandom_range(0, 65535)),
				DATA_W'($urandom_range(0, 65535)));
		send_item(ACT_SUMMARY, '0, '0, '0, '0);

		for (int n = 0; n < ITEMS; n++) begin
			// new mix of record kinds and idling every 50 items, none near the end
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: sat_pct = 10;
					1: sat_pct = 40;
					default: sat_pct = 70;
				endcase
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
			end
			if (n >= ITEMS - 100)
				idle_pct = 0;
			r = $urandom_range(0, 99);
			if (r < 20)
				a = ACT_SUMMARY;
			else if (r < 26)
				a = ACT_NONE;
			else if ($urandom_range(0, 99) < sat_pct)
				a = ACT_STORE_SAT;
			else
				a = ACT_STORE_EXP;
			send_item(a, pick_word(-16'sd800, 16'sd3392), pick_word(16'd0, 16'd25600),
				pick_word(16'd0, 16'hffff), pick_word(16'd0, 16'hffff));
			if ($urandom_range(0, 99) < idle_pct)
				hold_off($urandom_range(1, 18));
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (RING_DEPTH + 4) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
